FILE: hdl/nfps_pkg.sv
// Package for the Newton fractal pixel shader.
// Holds fixed-point constants, widths and the saturating helpers; no dependencies.
package nfps_pkg;

    localparam int QW        = 48;
    localparam int INDEX_W   = 12;
    localparam int COUNT_W   = 10;
    localparam int GRAY_W    = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_STEP   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 3'd4;

    localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW-1:0] QONE = 48'sh0001_0000_0000;
    localparam logic signed [QW-1:0] QESC = 48'sh0010_0000_0000;

    typedef logic signed [QW-1:0] q_t;

    // Saturates a 50-bit signed value to the 48-bit range.
    function automatic q_t sat50(input logic signed [QW+1:0] v);
        q_t r;
        if (v > $signed({{2{1'b0}}, QMAX}))
            r = QMAX;
        else if (v < $signed({{2{1'b1}}, QMIN}))
            r = QMIN;
        else
            r = v[QW-1:0];
        return r;
    endfunction

    function automatic q_t sadd(input q_t x, input q_t y);
        return sat50({{2{x[QW-1]}}, x} + {{2{y[QW-1]}}, y});
    endfunction

    function automatic q_t ssub(input q_t x, input q_t y);
        return sat50({{2{x[QW-1]}}, x} - {{2{y[QW-1]}}, y});
    endfunction

endpackage

FILE: hdl/nfps_stream_if.sv
// Valid/ready channel interfaces for the pixel request, the result and configuration.
// Depends on nfps_pkg for field widths.
interface nfps_pixel_if;
    logic                             valid;
    logic                             ready;
    logic [nfps_pkg::INDEX_W-1:0]     column;
    logic [nfps_pkg::INDEX_W-1:0]     row;
    modport source (output valid, column, row, input ready);
    modport sink (input valid, column, row, output ready);
endinterface

interface nfps_result_if;
    logic                             valid;
    logic                             ready;
    logic [nfps_pkg::INDEX_W-1:0]     out_column;
    logic [nfps_pkg::INDEX_W-1:0]     out_row;
    logic [nfps_pkg::COUNT_W-1:0]     step_count;
    logic [nfps_pkg::GRAY_W-1:0]      gray_level;
    modport source (output valid, out_column, out_row, step_count, gray_level, input ready);
    modport sink (input valid, out_column, out_row, step_count, gray_level, output ready);
endinterface

interface nfps_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nfps_pkg::REG_IDX_W-1:0]   index;
    logic [31:0]                      data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/nfps_fmul.sv
// Multicycle signed Q16.32 multiplier, floor rounding with saturation.
// Uses one 24x24 partial product per cycle; depends on nfps_pkg.
module nfps_fmul
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  nfps_pkg::q_t   x,
    input  nfps_pkg::q_t   y,
    output logic           done,
    output nfps_pkg::q_t   p
);

    logic [2:0]  phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic        neg_reg;
    logic [47:0] mx_reg, my_reg;
    logic [96:0] acc_reg, acc_next;
    logic        done_reg;
    nfps_pkg::q_t p_reg;
    logic [23:0] xa, yb;
    logic [47:0] pp;
    logic [96:0] pp_sh;
    logic [96:0] fl;
    nfps_pkg::q_t res;

    always_comb
    begin
        xa = phase_reg[1] ? mx_reg[47:24] : mx_reg[23:0];
        yb = phase_reg[0] ? my_reg[47:24] : my_reg[23:0];
        pp = xa * yb;
        unique case (phase_reg[1:0])
            2'd0: pp_sh = {49'd0, pp};
            2'd1, 2'd2: pp_sh = {25'd0, pp, 24'd0};
            default: pp_sh = {1'b0, pp, 48'd0};
        endcase
        acc_next = acc_reg + pp_sh;
        busy_next = busy_reg;
        phase_next = phase_reg;
        if (start)
        begin
            busy_next = 1'b1;
            phase_next = 3'd0;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 3'd1;
            if (phase_reg == 3'd4)
                busy_next = 1'b0;
        end
    end

    always_comb
    begin
        fl = acc_reg >> 32;
        if (!neg_reg)
        begin
            res = (fl > {49'd0, nfps_pkg::QMAX}) ? nfps_pkg::QMAX : fl[47:0];
        end
        else
        begin
            fl = fl + {96'd0, (acc_reg[31:0] != 32'd0)};
            res = (fl > 97'h8000_0000_0000) ? nfps_pkg::QMIN : -fl[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            phase_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            phase_reg <= phase_next;
            done_reg <= busy_reg && !start && phase_reg == 3'd4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= x[47] ^ y[47];
            mx_reg <= x[47] ? -x : x;
            my_reg <= y[47] ? -y : y;
            acc_reg <= '0;
        end
        else if (busy_reg && phase_reg < 3'd4)
            acc_reg <= acc_next;
        if (busy_reg && phase_reg == 3'd4)
            p_reg <= res;
    end

    // busy stays set through phase 4 so the result stage sees the final sum
    assign done = done_reg;
    assign p = p_reg;

endmodule

FILE: hdl/nfps_fdiv.sv
// Bit-serial restoring divider giving floor(n * 2^32 / d) with saturation.
// One quotient bit per cycle; depends on nfps_pkg.
module nfps_fdiv
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  nfps_pkg::q_t   n,
    input  nfps_pkg::q_t   d,
    output logic           done,
    output nfps_pkg::q_t   q
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg;
    logic [79:0] num_reg;
    logic [47:0] den_reg;
    logic [48:0] rem_reg;
    logic [48:0] quo_reg;
    logic        over_reg;
    logic        done_reg;
    nfps_pkg::q_t q_reg;
    logic [48:0] rsh;
    logic        ge;
    logic [48:0] qp;

    assign rsh = {rem_reg[47:0], num_reg[79]};
    assign ge = rsh >= {1'b0, den_reg};

    always_comb
    begin
        qp = quo_reg + {48'd0, (rem_reg != 49'd0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd80)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= n[47];
            num_reg <= {(n[47] ? -n : n), 32'd0};
            den_reg <= d;
            rem_reg <= '0;
            quo_reg <= '0;
            over_reg <= 1'b0;
        end
        else if (busy_reg && cnt_reg < 7'd80)
        begin
            num_reg <= {num_reg[78:0], 1'b0};
            rem_reg <= ge ? rsh - {1'b0, den_reg} : rsh;
            quo_reg <= {quo_reg[47:0], ge};
            if (quo_reg[47] || quo_reg[48])
                over_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (!neg_reg)
                q_reg <= (over_reg || quo_reg[48:47] != 2'd0) ? nfps_pkg::QMAX
                                                               : quo_reg[47:0];
            else
                q_reg <= (over_reg || qp > 49'h0_8000_0000_0000) ? nfps_pkg::QMIN
                                                                 : -qp[47:0];
        end
    end

    assign done = done_reg;
    assign q = q_reg;

endmodule

FILE: hdl/newton_fractal_pixel_shader_core.sv
// Top level of the Newton fractal pixel shader for z^2 - 1 with relaxation 1 + i.
// Depends on nfps_pkg, the channel interfaces, nfps_fmul and nfps_fdiv.
//
// Usage: software writes the origin, step and iteration limit registers over the
// cfg channel while the core is idle. Each transfer on the pixel channel names
// one pixel; the core answers with exactly one transfer on the result channel
// carrying the pixel coordinates, the Newton step count and a gray level.
// One pixel is worked on at a time; the pixel channel is not ready until the
// result has been handed off to the result register.
// Sequence: the setup states S_SX and S_SY, then per Newton step nine multiplies
// on the shared multiplier, two divisions on the bit-serial divider and the
// states S_TEST and S_UPD. The escape test that ends the loop follows the first
// three multiplies of a step.
// The gray level is then worked out on a shift-subtract divider, and S_OUT
// loads the result register.
// While the receiver stalls, the result is held; the next pixel is still taken
// and worked on, and waits in its last state until the result register frees.
// Reset returns the configuration registers to their defaults and idles the core.
// Configuration writes are always accepted.
module newton_fractal_pixel_shader_core
(
    input  logic         clk,
    input  logic         rst_n,
    nfps_cfg_if.sink     cfg,
    nfps_pixel_if.sink   pixel,
    nfps_result_if.source result
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SX    = 5'd1;
    localparam logic [4:0] S_SY    = 5'd2;
    localparam logic [4:0] S_AA    = 5'd3;
    localparam logic [4:0] S_BB    = 5'd4;
    localparam logic [4:0] S_AB    = 5'd5;
    localparam logic [4:0] S_TEST  = 5'd6;
    localparam logic [4:0] S_DRR   = 5'd7;
    localparam logic [4:0] S_DII   = 5'd8;
    localparam logic [4:0] S_M1    = 5'd9;
    localparam logic [4:0] S_M2    = 5'd10;
    localparam logic [4:0] S_M3    = 5'd11;
    localparam logic [4:0] S_M4    = 5'd12;
    localparam logic [4:0] S_D1    = 5'd13;
    localparam logic [4:0] S_D2    = 5'd14;
    localparam logic [4:0] S_UPD   = 5'd15;
    localparam logic [4:0] S_GRAY  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic signed [31:0] x_origin_reg, y_origin_reg;
    logic [30:0] x_step_reg, y_step_reg;
    logic [nfps_pkg::COUNT_W-1:0] limit_reg;

    logic [11:0] col_reg, row_reg;
    nfps_pkg::q_t a_reg, b_reg, aa_reg, bb_reg, ab_reg;
    nfps_pkg::q_t nr_reg, ni_reg, dr_reg, di_reg, den_reg;
    nfps_pkg::q_t t1_reg, t2_reg, qr_reg;
    logic [nfps_pkg::COUNT_W-1:0] count_reg;
    logic [17:0] gnum_reg;
    logic [7:0]  gq_reg;
    logic [4:0]  gcnt_reg;
    logic [17:0] grem_reg;
    logic        mwait_reg;

    logic        out_valid_reg;
    logic [11:0] out_col_reg, out_row_reg;
    logic [9:0]  out_cnt_reg;
    logic [7:0]  out_gray_reg;

    logic        mstart, mdone, dstart, ddone;
    nfps_pkg::q_t mx, my, mp, dn, dd, dq;

    logic signed [44:0] sprod;
    logic signed [44:0] spt;

    nfps_fmul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .x(mx), .y(my),
                     .done(mdone), .p(mp));
    nfps_fdiv u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .n(dn), .d(dd),
                     .done(ddone), .q(dq));

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= -32'sd1073741824;
            y_origin_reg <= -32'sd1073741824;
            x_step_reg <= 31'd3355443;
            y_step_reg <= 31'd4473924;
            limit_reg <= 10'd100;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                nfps_pkg::REG_X_ORIGIN: x_origin_reg <= cfg.data;
                nfps_pkg::REG_Y_ORIGIN: y_origin_reg <= cfg.data;
                nfps_pkg::REG_X_STEP:   x_step_reg <= cfg.data[30:0];
                nfps_pkg::REG_Y_STEP:   y_step_reg <= cfg.data[30:0];
                nfps_pkg::REG_LIMIT:    limit_reg <= cfg.data[9:0];
                default: ;
            endcase
        end
    end

    assign pixel.ready = (state_reg == S_IDLE);

    // Start point: origin + index * step, Q4.28 to Q16.32 with saturation.
    always_comb
    begin
        if (state_reg == S_SX)
        begin
            sprod = $signed({2'b0, {31'd0, col_reg} * {12'd0, x_step_reg}});
            spt = sprod + {{13{x_origin_reg[31]}}, x_origin_reg};
        end
        else
        begin
            sprod = $signed({2'b0, {31'd0, row_reg} * {12'd0, y_step_reg}});
            spt = sprod + {{13{y_origin_reg[31]}}, y_origin_reg};
        end
    end

    function automatic nfps_pkg::q_t conv(input logic signed [44:0] s);
        nfps_pkg::q_t r;
        if (s >= 45'sh800_0000_0000)
            r = nfps_pkg::QMAX;
        else if (s < -45'sh800_0000_0000)
            r = nfps_pkg::QMIN;
        else
            r = {s[43:0], 4'd0};
        return r;
    endfunction

    // Multiplier operand selection per sequencer step.
    always_comb
    begin
        mx = a_reg;
        my = a_reg;
        unique case (state_reg)
            S_BB:  begin mx = b_reg;  my = b_reg;  end
            S_AB:  begin mx = a_reg;  my = b_reg;  end
            S_DRR: begin mx = dr_reg; my = dr_reg; end
            S_DII: begin mx = di_reg; my = di_reg; end
            S_M1:  begin mx = nr_reg; my = dr_reg; end
            S_M2:  begin mx = ni_reg; my = di_reg; end
            S_M3:  begin mx = ni_reg; my = dr_reg; end
            S_M4:  begin mx = nr_reg; my = di_reg; end
            default: ;
        endcase
    end

    assign mstart = !mwait_reg && (state_reg == S_AA || state_reg == S_BB ||
                    state_reg == S_AB || state_reg == S_DRR || state_reg == S_DII ||
                    state_reg == S_M1 || state_reg == S_M2 || state_reg == S_M3 ||
                    state_reg == S_M4);
    assign dstart = !mwait_reg && (state_reg == S_D1 || state_reg == S_D2);
    assign dn = t1_reg;
    assign dd = den_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (pixel.valid) state_next = S_SX;
            S_SX:   state_next = S_SY;
            S_SY:   state_next = (limit_reg == 10'd0) ? S_GRAY : S_AA;
            S_AA, S_BB, S_AB, S_DRR, S_M1, S_M2, S_M3:
                if (mdone) state_next = state_reg + 5'd1;
            // Vanishing divisor ends the loop after counting the step.
            S_DII:
                if (mdone)
                    state_next = (nfps_pkg::sadd(den_reg, mp) == '0) ? S_GRAY : S_M1;
            S_M4:   if (mdone) state_next = S_D1;
            S_TEST:
                if (nfps_pkg::sadd(aa_reg, bb_reg) >= nfps_pkg::QESC)
                    state_next = S_GRAY;
                else
                    state_next = S_DRR;
            S_D1:   if (ddone) state_next = S_D2;
            S_D2:   if (ddone) state_next = S_UPD;
            S_UPD:  state_next = (count_reg >= limit_reg) ? S_GRAY : S_AA;
            S_GRAY: if (gcnt_reg == 5'd18) state_next = S_OUT;
            S_OUT:  if (!out_valid_reg || result.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mwait_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_TEST && state_next == S_DRR)
                state_reg <= S_DRR;
            else
                state_reg <= state_next;
            if (state_next != state_reg)
                mwait_reg <= 1'b0;
            else if (mstart || dstart)
                mwait_reg <= 1'b1;
            if (state_reg == S_OUT && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (pixel.valid)
                begin
                    col_reg <= pixel.column;
                    row_reg <= pixel.row;
                    count_reg <= '0;
                end
            S_SX:  a_reg <= conv(spt);
            S_SY:  b_reg <= conv(spt);
            S_AA:  if (mdone) aa_reg <= mp;
            S_BB:  if (mdone) bb_reg <= mp;
            S_AB:  if (mdone) ab_reg <= mp;
            S_TEST:
                if (nfps_pkg::sadd(aa_reg, bb_reg) < nfps_pkg::QESC)
                begin
                    count_reg <= count_reg + 10'd1;
                    nr_reg <= nfps_pkg::ssub(nfps_pkg::ssub(aa_reg, bb_reg), nfps_pkg::QONE);
                    ni_reg <= nfps_pkg::sadd(ab_reg, ab_reg);
                    dr_reg <= nfps_pkg::sadd(a_reg, a_reg);
                    di_reg <= nfps_pkg::sadd(b_reg, b_reg);
                end
            S_DRR: if (mdone) den_reg <= mp;
            S_DII: if (mdone) den_reg <= nfps_pkg::sadd(den_reg, mp);
            S_M1:  if (mdone) t1_reg <= mp;
            S_M2:  if (mdone) t1_reg <= nfps_pkg::sadd(t1_reg, mp);
            S_M3:  if (mdone) t2_reg <= mp;
            S_M4:  if (mdone) t2_reg <= nfps_pkg::ssub(t2_reg, mp);
            S_D1:  if (ddone)
                   begin
                       qr_reg <= dq;
                       t1_reg <= t2_reg;
                   end
            S_D2:  if (ddone) t2_reg <= dq;
            S_UPD:
            begin
                a_reg <= nfps_pkg::ssub(a_reg, nfps_pkg::ssub(qr_reg, t2_reg));
                b_reg <= nfps_pkg::ssub(b_reg, nfps_pkg::sadd(qr_reg, t2_reg));
            end
            default: ;
        endcase
        if (state_next == S_GRAY && state_reg != S_GRAY)
        begin
            gnum_reg <= {count_reg, 8'd0} - {8'd0, count_reg};
            grem_reg <= '0;
            gq_reg <= '0;
            gcnt_reg <= '0;
        end
        else if (state_reg == S_GRAY && gcnt_reg < 5'd18)
        begin
            gcnt_reg <= gcnt_reg + 5'd1;
            if (limit_reg == 10'd0)
            begin
                gq_reg <= '0;
                gcnt_reg <= 5'd18;
            end
            else
            begin
                gnum_reg <= {gnum_reg[16:0], 1'b0};
                if ({grem_reg[16:0], gnum_reg[17]} >= {8'd0, limit_reg})
                begin
                    grem_reg <= {grem_reg[16:0], gnum_reg[17]} - {8'd0, limit_reg};
                    gq_reg <= {gq_reg[6:0], 1'b1};
                end
                else
                begin
                    grem_reg <= {grem_reg[16:0], gnum_reg[17]};
                    gq_reg <= {gq_reg[6:0], 1'b0};
                end
            end
        end
        if (state_reg == S_OUT && (!out_valid_reg || result.ready))
        begin
            out_col_reg <= col_reg;
            out_row_reg <= row_reg;
            out_cnt_reg <= count_reg;
            out_gray_reg <= gq_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.out_column = out_col_reg;
    assign result.out_row = out_row_reg;
    assign result.step_count = out_cnt_reg;
    assign result.gray_level = out_gray_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> !pixel.ready)
        else $error("pixel taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_SX && state_reg != S_SY)
        |-> count_reg <= limit_reg)
        else $error("step count passed limit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> result.valid)
        else $error("result dropped under stall");

endmodule
